// File: hw/rtl/format_directive_tokenizer_defines.svh
// Assertion helpers shared by the tokenizer RTL
`ifndef FORMAT_DIRECTIVE_TOKENIZER_DEFINES_SVH
`define FORMAT_DIRECTIVE_TOKENIZER_DEFINES_SVH

// Condition must hold at every clock edge outside reset
`define FDT_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define FDT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/fdt_pkg.sv
package fdt_pkg;

   typedef enum logic [1:0] {
      KIND_LITERAL   = 2'd0,
      KIND_OPEN      = 2'd1,
      KIND_TEXT      = 2'd2,
      KIND_DIRECTIVE = 2'd3
   } kind_type;

   typedef enum logic [5:0] {
      MODE_TEXT     = 6'b000001,
      MODE_PREFIX   = 6'b000010,
      MODE_BRACE    = 6'b000100,
      MODE_MINUS    = 6'b001000,
      MODE_COUNT    = 6'b010000,
      MODE_FRACTION = 6'b100000
   } mode_type;

   localparam logic [7:0] CHAR_TILDE = 8'h7E;
   localparam logic [7:0] CHAR_SHARP = 8'h23;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   localparam logic [4:0] FLAG_SHARP = 5'b00001;
   localparam logic [4:0] FLAG_STAR  = 5'b00010;
   localparam logic [4:0] FLAG_AT    = 5'b00100;
   localparam logic [4:0] FLAG_MINUS = 5'b01000;
   localparam logic [4:0] FLAG_ZERO  = 5'b10000;

   localparam logic [7:0] DIGITS_MAX = 8'hFF;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  byte_value;
      logic        has_modifiers;
      logic [4:0]  flag_bits;
      logic        count_present;
      logic [15:0] count_value;
      logic        fraction_present;
      logic [7:0]  fraction_digits;
      logic [15:0] fraction_value;
      logic        brace_present;
      logic        run_last;
      logic        text_end;
   } rsp_type;

endpackage

// File: hw/rtl/format_directive_tokenizer.sv
// Format string tokenizer. Takes one byte per cycle while req_ready is high and splits
// the string into literal bytes, brace-group markers and bytes, and directives with
// their flags, count and fraction fields. Each input item updates the small parser
// registers and pushes zero, one or two results into a four-entry result queue; the
// queue drains one result per cycle while rsp_ready is high. req_ready is high whenever
// the queue has room for two results, so a byte per cycle is sustained as long as
// results are taken at least as fast as they are made. Decimal fields saturate at
// 2**NUMBER_WIDTH-1 and are presented on 16-bit ports.
module format_directive_tokenizer #(
   parameter int NUMBER_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_text_byte,
   input  logic                 req_text_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [7:0]           rsp_byte_value,
   output logic                 rsp_has_modifiers,
   output logic [4:0]           rsp_flag_bits,
   output logic                 rsp_count_present,
   output logic [15:0]          rsp_count_value,
   output logic                 rsp_fraction_present,
   output logic [7:0]           rsp_fraction_digits,
   output logic [15:0]          rsp_fraction_value,
   output logic                 rsp_brace_present,
   output logic                 rsp_run_last,
   output logic                 rsp_text_end
);
   import fdt_pkg::*;
   `include "format_directive_tokenizer_defines.svh"

   localparam int NW = NUMBER_WIDTH;
   localparam logic [NW-1:0] NUM_MAX = {NW{1'b1}};

   function automatic logic [NW-1:0] accumulate(input logic [NW-1:0] v, input logic [3:0] d);
      logic [NW+3:0] r;
      r = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{NW{1'b0}}, d};
      accumulate = (r[NW+3:NW] != 4'b0) ? NUM_MAX : r[NW-1:0];
   endfunction

   function automatic logic [15:0] to_port(input logic [NW-1:0] v);
      logic [NW+15:0] t;
      t = {16'b0, v};
      to_port = t[15:0];
   endfunction

   mode_type    mode_ff, mode_in;
   logic [4:0]  flags_ff, flags_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic        cnt_seen_ff, cnt_seen_in;
   logic [NW-1:0] frac_ff, frac_in;
   logic [7:0]  frac_dig_ff, frac_dig_in;
   logic        frac_seen_ff, frac_seen_in;
   logic        brace_ff, brace_in;
   logic        mod_ff, mod_in;

   rsp_type     queue_ff [4];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  level_ff, level_in;

   logic        accept, pop;
   logic        is_digit, is_flag;
   logic [3:0]  dval;
   logic        a_vld, b_vld;
   rsp_type     res_a, res_b, head;
   logic [1:0]  idx_b;

   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (level_ff <= 3'd2);
   assign is_digit  = (req_text_byte inside {[CHAR_ZERO:CHAR_NINE]});
   assign is_flag   = (req_text_byte inside {CHAR_SHARP, CHAR_STAR, CHAR_AT});
   assign dval      = req_text_byte[3:0];

   always_comb begin
      mode_in      = mode_ff;
      flags_in     = flags_ff;
      cnt_in       = cnt_ff;
      cnt_seen_in  = cnt_seen_ff;
      frac_in      = frac_ff;
      frac_dig_in  = frac_dig_ff;
      frac_seen_in = frac_seen_ff;
      brace_in     = brace_ff;
      mod_in       = mod_ff;
      res_a        = '0;
      res_b        = '0;
      a_vld        = 1'b0;
      b_vld        = 1'b0;

      if (accept) begin
         case (mode_ff)
            MODE_BRACE: begin
               if (req_text_byte == CHAR_RBRACE) begin
                  mode_in = MODE_PREFIX;
               end else begin
                  a_vld            = 1'b1;
                  res_a.kind       = KIND_TEXT;
                  res_a.byte_value = req_text_byte;
               end
            end
            MODE_PREFIX, MODE_MINUS, MODE_COUNT, MODE_FRACTION: begin
               if (mode_ff == MODE_PREFIX && is_flag) begin
                  if (req_text_byte == CHAR_SHARP) begin
                     flags_in = flags_ff | FLAG_SHARP;
                  end else if (req_text_byte == CHAR_STAR) begin
                     flags_in = flags_ff | FLAG_STAR;
                  end else begin
                     flags_in = flags_ff | FLAG_AT;
                  end
                  mod_in = 1'b1;
               end else if (mode_ff == MODE_PREFIX && req_text_byte == CHAR_LBRACE) begin
                  a_vld      = 1'b1;
                  res_a.kind = KIND_OPEN;
                  brace_in   = 1'b1;
                  mod_in     = 1'b1;
                  mode_in    = MODE_BRACE;
               end else if (mode_ff == MODE_PREFIX && req_text_byte == CHAR_MINUS) begin
                  flags_in = flags_ff | FLAG_MINUS;
                  mod_in   = 1'b1;
                  mode_in  = MODE_MINUS;
               end else if (is_digit && (mode_ff == MODE_PREFIX || mode_ff == MODE_MINUS)) begin
                  cnt_seen_in = 1'b1;
                  if (req_text_byte == CHAR_ZERO) begin
                     flags_in = flags_ff | FLAG_ZERO;
                  end
                  cnt_in  = accumulate('0, dval);
                  mod_in  = 1'b1;
                  mode_in = MODE_COUNT;
               end else if (is_digit && mode_ff == MODE_COUNT) begin
                  cnt_in = accumulate(cnt_ff, dval);
               end else if (req_text_byte == CHAR_DOT && mode_ff != MODE_FRACTION) begin
                  frac_seen_in = 1'b1;
                  mod_in       = 1'b1;
                  mode_in      = MODE_FRACTION;
               end else if (is_digit && mode_ff == MODE_FRACTION) begin
                  if (frac_dig_ff != DIGITS_MAX) begin
                     frac_dig_in = frac_dig_ff + 8'd1;
                  end
                  frac_in = accumulate(frac_ff, dval);
               end else begin
                  // directive byte: emit with everything collected so far
                  a_vld                  = 1'b1;
                  res_a.kind             = KIND_DIRECTIVE;
                  res_a.byte_value       = req_text_byte;
                  res_a.has_modifiers    = mod_ff;
                  res_a.flag_bits        = flags_ff;
                  res_a.count_present    = cnt_seen_ff;
                  res_a.count_value      = to_port(cnt_ff);
                  res_a.fraction_present = frac_seen_ff;
                  res_a.fraction_digits  = frac_dig_ff;
                  res_a.fraction_value   = to_port(frac_ff);
                  res_a.brace_present    = brace_ff;
                  mode_in                = MODE_TEXT;
               end
            end
            default: begin
               mode_in = MODE_TEXT;
               if (req_text_byte == CHAR_TILDE && !req_text_last) begin
                  flags_in     = '0;
                  cnt_in       = '0;
                  cnt_seen_in  = 1'b0;
                  frac_in      = '0;
                  frac_dig_in  = '0;
                  frac_seen_in = 1'b0;
                  brace_in     = 1'b0;
                  mod_in       = 1'b0;
                  mode_in      = MODE_PREFIX;
               end else begin
                  a_vld            = 1'b1;
                  res_a.kind       = KIND_LITERAL;
                  res_a.byte_value = req_text_byte;
               end
            end
         endcase

         if (req_text_last) begin
            // text ended inside a directive: flush it with a zero byte
            if (mode_in != MODE_TEXT) begin
               b_vld                  = 1'b1;
               res_b.kind             = KIND_DIRECTIVE;
               res_b.has_modifiers    = mod_in;
               res_b.flag_bits        = flags_in;
               res_b.count_present    = cnt_seen_in;
               res_b.count_value      = to_port(cnt_in);
               res_b.fraction_present = frac_seen_in;
               res_b.fraction_digits  = frac_dig_in;
               res_b.fraction_value   = to_port(frac_in);
               res_b.brace_present    = brace_in;
               res_b.run_last         = 1'b1;
               res_b.text_end         = 1'b1;
            end
            mode_in      = MODE_TEXT;
            flags_in     = '0;
            cnt_in       = '0;
            cnt_seen_in  = 1'b0;
            frac_in      = '0;
            frac_dig_in  = '0;
            frac_seen_in = 1'b0;
            brace_in     = 1'b0;
            mod_in       = 1'b0;
         end
         res_a.run_last = !b_vld;
         res_a.text_end = req_text_last && !b_vld;
      end
   end

   assign idx_b     = a_vld ? (wr_ptr_ff + 2'd1) : wr_ptr_ff;
   assign wr_ptr_in = wr_ptr_ff + {1'b0, a_vld} + {1'b0, b_vld};
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign level_in  = level_ff + {2'b0, a_vld} + {2'b0, b_vld} - {2'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_TEXT;
         flags_ff     <= '0;
         cnt_ff       <= '0;
         cnt_seen_ff  <= 1'b0;
         frac_ff      <= '0;
         frac_dig_ff  <= '0;
         frac_seen_ff <= 1'b0;
         brace_ff     <= 1'b0;
         mod_ff       <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         level_ff     <= '0;
      end else begin
         mode_ff      <= mode_in;
         flags_ff     <= flags_in;
         cnt_ff       <= cnt_in;
         cnt_seen_ff  <= cnt_seen_in;
         frac_ff      <= frac_in;
         frac_dig_ff  <= frac_dig_in;
         frac_seen_ff <= frac_seen_in;
         brace_ff     <= brace_in;
         mod_ff       <= mod_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         level_ff     <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_vld) begin
         queue_ff[wr_ptr_ff] <= res_a;
      end
      if (b_vld) begin
         queue_ff[idx_b] <= res_b;
      end
   end

   assign head                 = queue_ff[rd_ptr_ff];
   assign rsp_valid            = (level_ff != 3'd0);
   assign rsp_kind             = head.kind;
   assign rsp_byte_value       = head.byte_value;
   assign rsp_has_modifiers    = head.has_modifiers;
   assign rsp_flag_bits        = head.flag_bits;
   assign rsp_count_present    = head.count_present;
   assign rsp_count_value      = head.count_value;
   assign rsp_fraction_present = head.fraction_present;
   assign rsp_fraction_digits  = head.fraction_digits;
   assign rsp_fraction_value   = head.fraction_value;
   assign rsp_brace_present    = head.brace_present;
   assign rsp_run_last         = head.run_last;
   assign rsp_text_end         = head.text_end;

   `FDT_ASSERT_ALWAYS(a_level_bound, level_ff <= 3'd4, "result queue overfilled")
   `FDT_ASSERT_NEXT(a_last_to_text, accept && req_text_last, mode_ff == MODE_TEXT,
                    "mode not text after last item")
   `FDT_ASSERT_NEXT(a_last_clears, accept && req_text_last,
                    !mod_ff && flags_ff == 5'b0 && !brace_ff,
                    "pending fields not cleared after last item")
   `FDT_ASSERT_NEXT(a_pop_only, pop && !accept, level_ff == $past(level_ff) - 3'd1,
                    "queue level did not drop on pop")

endmodule
